@@ hdl/fdtp_pkg.sv @@
// Shared types and constants of the device tree structure block parser.
package fdtp_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SKIP_W   = 31;

  // Structure block tokens.
  localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [WORD_W-1:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [WORD_W-1:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [WORD_W-1:0] TOK_END        = 32'h0000_0009;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STRUCT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRINGS_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT   = 2'd2;

  typedef enum logic [2:0] {
    PH_TOKEN = 3'd0,
    PH_NAME  = 3'd1,
    PH_LEN   = 3'd2,
    PH_OFF   = 3'd3,
    PH_DATA  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_BEGIN    = 3'd0,
    EV_END_NODE = 3'd1,
    EV_PROP     = 3'd2,
    EV_NOP      = 3'd3,
    EV_END      = 3'd4,
    EV_ERROR    = 3'd5
  } event_t;

  typedef struct packed {
    logic [WORD_W-1:0] struct_base;
    logic [WORD_W-1:0] strings_base;
    logic [WORD_W-1:0] size_limit;
  } cfg_t;

  typedef struct packed {
    event_t            event_res;
    logic [WORD_W-1:0] name_addr;
    logic [WORD_W-1:0] data_addr;
    logic [WORD_W-1:0] data_len;
  } res_t;

endpackage

@@ hdl/fdtp_word_if.sv @@
// Stream interface that carries structure block words.
interface fdtp_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

@@ hdl/fdtp_event_if.sv @@
// Stream interface that carries decoded token events.
interface fdtp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] name_addr;
  logic [31:0] data_addr;
  logic [31:0] data_len;

  modport source (output valid, output event_res, output name_addr, output data_addr,
                  output data_len, input ready);
  modport sink   (input valid, input event_res, input name_addr, input data_addr,
                  input data_len, output ready);
endinterface

@@ hdl/fdtp_cfg_if.sv @@
// Write channel for the configuration registers.
interface fdtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hdl/fdtp_cfg_regs.sv @@
// Configuration registers of the parser.
module fdtp_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  fdtp_cfg_if.sink        cfg,
  output fdtp_pkg::cfg_t  regs
);
  import fdtp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        CFG_STRUCT_BASE:  regs.struct_base  <= cfg.wdata;
        CFG_STRINGS_BASE: regs.strings_base <= cfg.wdata;
        CFG_SIZE_LIMIT:   regs.size_limit   <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/fdtp_decoder.sv @@
// Token state machine: decodes one word per accepted request.
module fdtp_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [fdtp_pkg::WORD_W-1:0]  word,
  input  fdtp_pkg::cfg_t               regs,
  output logic                         res_valid,
  output fdtp_pkg::res_t               res,
  output fdtp_pkg::phase_t             phase
);
  import fdtp_pkg::*;

  phase_t             phase_next;
  logic [WORD_W-1:0]  byte_pos;
  logic [WORD_W-1:0]  byte_pos_next;
  logic [SKIP_W-1:0]  skip_words;
  logic [SKIP_W-1:0]  skip_words_next;
  logic [WORD_W-1:0]  held_len;
  logic [WORD_W-1:0]  held_len_next;
  logic [WORD_W-1:0]  pos_plus4;
  logic [WORD_W:0]    len_round;
  logic               past_limit;
  logic               has_zero;
  logic               emit;

  assign pos_plus4  = byte_pos + WORD_W'(4);
  assign len_round  = {1'b0, held_len} + (WORD_W+1)'(3);
  assign past_limit = (byte_pos >= regs.size_limit);
  assign has_zero   = (word[31:24] == 8'h00) || (word[23:16] == 8'h00) ||
                      (word[15:8] == 8'h00) || (word[7:0] == 8'h00);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_TOKEN: begin
        if (past_limit) begin
          phase_next = PH_DONE;
        end else begin
          case (word)
            TOK_BEGIN_NODE: phase_next = PH_NAME;
            TOK_END_NODE:   phase_next = PH_TOKEN;
            TOK_PROP:       phase_next = PH_LEN;
            TOK_NOP:        phase_next = PH_TOKEN;
            default:        phase_next = PH_DONE;
          endcase
        end
      end
      PH_NAME: begin
        if (has_zero) phase_next = PH_TOKEN;
      end
      PH_LEN:  phase_next = PH_OFF;
      PH_OFF:  phase_next = (len_round[WORD_W:2] != '0) ? PH_DATA : PH_TOKEN;
      PH_DATA: begin
        if (skip_words <= SKIP_W'(1)) phase_next = PH_TOKEN;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  always_comb begin
    emit            = 1'b0;
    res             = '0;
    res.event_res   = EV_BEGIN;
    byte_pos_next   = (phase == PH_DONE) ? byte_pos : pos_plus4;
    skip_words_next = skip_words;
    held_len_next   = held_len;
    unique case (phase)
      PH_TOKEN: begin
        emit = 1'b1;
        if (past_limit) begin
          res.event_res = EV_ERROR;
        end else begin
          case (word)
            TOK_BEGIN_NODE: begin
              res.event_res = EV_BEGIN;
              res.name_addr = regs.struct_base + pos_plus4;
            end
            TOK_END_NODE: res.event_res = EV_END_NODE;
            TOK_PROP:     emit = 1'b0;
            TOK_NOP:      res.event_res = EV_NOP;
            TOK_END:      res.event_res = EV_END;
            default:      res.event_res = EV_ERROR;
          endcase
        end
      end
      PH_LEN: held_len_next = word;
      PH_OFF: begin
        emit            = 1'b1;
        skip_words_next = len_round[WORD_W:2];
        held_len_next   = '0;
        res.event_res   = EV_PROP;
        res.name_addr   = regs.strings_base + word;
        res.data_addr   = regs.struct_base + pos_plus4;
        res.data_len    = held_len;
      end
      PH_DATA: begin
        if (skip_words != '0) skip_words_next = skip_words - SKIP_W'(1);
      end
      default: ;
    endcase
  end

  assign res_valid = take & emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TOKEN;
      byte_pos   <= '0;
      skip_words <= '0;
      held_len   <= '0;
    end else if (take) begin
      phase      <= phase_next;
      byte_pos   <= byte_pos_next;
      skip_words <= skip_words_next;
      held_len   <= held_len_next;
    end
  end

endmodule

@@ hdl/fdtp_out_buf.sv @@
// Output register with a skid stage in front of the event channel.
module fdtp_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fdtp_pkg::res_t  push_data,
  output logic            space,
  fdtp_event_if.source    events
);
  import fdtp_pkg::*;

  logic  out_valid;
  res_t  out_data;
  logic  skid_valid;
  res_t  skid_data;
  logic  load_out;

  assign space    = !skid_valid;
  assign load_out = !out_valid || events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (!load_out && push) begin
      skid_data <= push_data;
    end
  end

  assign events.valid     = out_valid;
  assign events.event_res = out_data.event_res;
  assign events.name_addr = out_data.name_addr;
  assign events.data_addr = out_data.data_addr;
  assign events.data_len  = out_data.data_len;

endmodule

@@ hdl/fdt_struct_block_parser_top.sv @@
// Top level of the flattened device tree structure block parser.
//
//   channel  direction  payload                                  handshake
//   words    in         word[31:0], first byte in bits 31..24    valid/ready
//   events   out        event_res, name_addr, data_addr, data_len  valid/ready
//   cfg      in         reg_index[1:0], wdata[31:0]              valid/ready
//
// The parser accepts one word per cycle while the skid register is free. Each word
// is decoded in the cycle it is accepted, and the event it causes is registered in
// the output register, or in the skid register behind it, which keeps words flowing
// while the event sink stalls; words are refused only once both hold an event.
// Reset is synchronous and returns the parser to the token phase at byte zero,
// with all configuration registers cleared. Configuration writes are always taken.
module fdt_struct_block_parser_top (
  input  logic        clk,
  input  logic        rst,
  fdtp_word_if.sink   words,
  fdtp_event_if.source events,
  fdtp_cfg_if.sink    cfg
);
  import fdtp_pkg::*;

  cfg_t    regs;
  res_t    res;
  logic    res_valid;
  logic    space;
  logic    take;
  phase_t  phase;

  // Configuration registers take effect in the cycle after the write.
  fdtp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // A word is accepted whenever the skid stage is free, so the decoder always
  // has somewhere to put the event the word may cause.
  assign words.ready = space;
  assign take        = words.valid & space;

  fdtp_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (words.word),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res),
    .phase     (phase)
  );

  fdtp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .events    (events)
  );

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !events.valid)
    else $error("event output valid after reset");

  // The skid stage only fills behind a held output event.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    !words.ready |-> events.valid)
    else $error("input stalled with empty output register");

  // After end or an error no further events are produced.
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> !res_valid)
    else $error("event produced after end of stream");

  // An event is only produced by an accepted word.
  a_event_needs_word: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (words.valid && words.ready))
    else $error("event without an accepted word");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the structure block parser: directed table, then random token groups.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fdtp_pkg::*;

  // Cycles to let pass after the last expected event before the parser counts as idle.
  // The header promises the event in the output register or in its skid slot.
  localparam int DRAIN_CYCLES = 4;
  // Cycles without any accepted request before the run is declared hung. The longest
  // legal quiet spell is the forced sink hold-off below plus a few random gaps.
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int WORD_TARGET  = 1450;
  localparam int IDLE_PCT     = 14;
  // The register file decodes two index bits but only three registers exist.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // How the single stream of the run is brought to its end. Reset is applied only
  // once, so only one terminal condition can be exercised per seed.
  typedef enum {
    CLOSE_END_TOKEN,
    CLOSE_BAD_TOKEN,
    CLOSE_SIZE_LIMIT,
    CLOSE_HUGE_PROP
  } close_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    value;
    bit                   typed;
    res_t                 want;
  } dir_row_t;

  logic clk;
  logic rst;

  fdtp_word_if  word_ch ();
  fdtp_event_if event_ch ();
  fdtp_cfg_if   cfg_ch ();

  fdt_struct_block_parser_top u_top (
    .clk    (clk),
    .rst    (rst),
    .words  (word_ch),
    .events (event_ch),
    .cfg    (cfg_ch)
  );

  // Shadow of the configuration registers and of the decoder state.
  cfg_t              reg_shadow;
  phase_t            parse_phase;
  logic [WORD_W-1:0] parse_pos;
  logic [SKIP_W-1:0] skip_left;
  logic [WORD_W-1:0] pend_len;

  // Events predicted for accepted words and not yet seen on the event channel.
  res_t     pending_events[$];
  dir_row_t dir_rows[$];

  int     errors;
  int     words_sent;
  int     reg_writes;
  int     ev_seen[6];
  int     quiet_cycles;
  bit     calm;
  bit     hold_req;
  bit     pressure_done;
  close_t close_kind;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Decodes one accepted word against the shadow state. Returns 1 when the word
  // causes an event, which is then written to ev.
  function automatic bit decode_word(input logic [WORD_W-1:0] w, output res_t ev);
    logic [WORD_W-1:0] here;
    logic [WORD_W:0]   span;
    ev   = '0;
    here = parse_pos;
    if (parse_phase == PH_DONE) return 1'b0;
    parse_pos = parse_pos + 32'd4;
    case (parse_phase)
      PH_TOKEN: begin
        // The size check applies to token words only, and wins over any decode.
        if (here >= reg_shadow.size_limit) begin
          parse_phase  = PH_DONE;
          ev.event_res = EV_ERROR;
          return 1'b1;
        end
        case (w)
          TOK_BEGIN_NODE: begin
            parse_phase  = PH_NAME;
            ev.event_res = EV_BEGIN;
            ev.name_addr = reg_shadow.struct_base + parse_pos;
            return 1'b1;
          end
          TOK_END_NODE: begin
            ev.event_res = EV_END_NODE;
            return 1'b1;
          end
          TOK_PROP: begin
            parse_phase = PH_LEN;
            return 1'b0;
          end
          TOK_NOP: begin
            ev.event_res = EV_NOP;
            return 1'b1;
          end
          TOK_END: begin
            parse_phase  = PH_DONE;
            ev.event_res = EV_END;
            return 1'b1;
          end
          default: begin
            parse_phase  = PH_DONE;
            ev.event_res = EV_ERROR;
            return 1'b1;
          end
        endcase
      end
      PH_NAME: begin
        // The name ends with the word that carries its zero byte.
        if (w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 || w[7:0] == 8'h00)
          parse_phase = PH_TOKEN;
        return 1'b0;
      end
      PH_LEN: begin
        pend_len    = w;
        parse_phase = PH_OFF;
        return 1'b0;
      end
      PH_OFF: begin
        // Data is padded to whole words; the sum needs the carry bit.
        span         = ({1'b0, pend_len} + 33'd3) >> 2;
        skip_left    = span[SKIP_W-1:0];
        ev.event_res = EV_PROP;
        ev.name_addr = reg_shadow.strings_base + w;
        ev.data_addr = reg_shadow.struct_base + parse_pos;
        ev.data_len  = pend_len;
        pend_len     = '0;
        parse_phase  = (skip_left != '0) ? PH_DATA : PH_TOKEN;
        return 1'b1;
      end
      PH_DATA: begin
        if (skip_left != '0) skip_left = skip_left - SKIP_W'(1);
        if (skip_left == '0) parse_phase = PH_TOKEN;
        return 1'b0;
      end
      default: begin
        parse_phase = PH_DONE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, seen);
    end
  endfunction

  function automatic void row_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] value);
    dir_row_t row;
    row        = '{default: '0};
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.value  = value;
    dir_rows.push_back(row);
  endfunction

  // A word row; when typed is set the event is spelled out in the table.
  function automatic void row_word(input logic [WORD_W-1:0] w, input bit typed = 1'b0,
                                   input event_t ev = EV_NOP,
                                   input logic [WORD_W-1:0] name = '0);
    dir_row_t row;
    row                = '{default: '0};
    row.value          = w;
    row.typed          = typed;
    row.want           = '0;
    row.want.event_res = ev;
    row.want.name_addr = name;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [WORD_W-1:0] pick_addr();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFC;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word request, with random idle cycles in front of it, and predicts
  // its event once the request is accepted.
  task automatic send_word(input logic [WORD_W-1:0] w, input bit typed = 1'b0,
                           input res_t want = '0);
    res_t ev;
    bit   has_ev;
    if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
    // A stretch in the middle of the run goes with no idling on either side.
    calm = (words_sent >= 700 && words_sent < 900);
    if (!pressure_done && words_sent >= 400) begin
      pressure_done = 1'b1;
      hold_req      = 1'b1;
    end
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      word_ch.valid <= 1'b0;
      @(posedge clk);
    end
    word_ch.valid <= 1'b1;
    word_ch.word  <= w;
    do @(posedge clk); while (!word_ch.ready);
    has_ev = decode_word(w, ev);
    if (typed) begin
      has_ev = 1'b1;
      ev     = want;
    end
    if (has_ev) pending_events.push_back(ev);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_STRUCT_BASE:  reg_shadow.struct_base  = value;
      CFG_STRINGS_BASE: reg_shadow.strings_base = value;
      CFG_SIZE_LIMIT:   reg_shadow.size_limit   = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Stops offering requests and waits until every predicted event has arrived,
  // then a few cycles more for words that cause no event.
  task automatic settle_block();
    word_ch.valid <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One well-formed token with its trailing words and random content.
  task automatic send_token_group();
    int                kind;
    int                pick;
    int                n_name;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] tail;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_word(TOK_BEGIN_NODE);
      n_name = $urandom_range(0, 3);
      repeat (n_name)
        send_word({8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))});
      // The closing name word has one or more zero bytes anywhere in it.
      tail = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
      for (int b = 0; b < 4; b++)
        if ($urandom_range(0, 2) == 0) tail[b*8 +: 8] = 8'h00;
      tail[$urandom_range(0, 3)*8 +: 8] = 8'h00;
      send_word(tail);
    end else if (kind < 50) begin
      send_word(TOK_END_NODE);
    end else if (kind < 85) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(0, 12);
      else if (pick < 95) len = $urandom_range(13, 64);
      else                len = $urandom_range(65, 400);
      send_word(TOK_PROP);
      send_word(len);
      send_word($urandom);
      repeat ((len + 3) / 4) send_word($urandom);
    end else begin
      send_word(TOK_NOP);
    end
  endtask

  // Event sink: random ready, a calm stretch, and one long hold-off so that the
  // output register and its skid slot fill and the word channel stalls.
  initial begin
    event_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        event_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        event_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Every accepted event is compared with the oldest prediction, field by field.
  always @(posedge clk) begin : event_check
    res_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: event %0d arrived with nothing expected, expected none, actual %h",
                   $time, event_ch.event_res, event_ch.name_addr);
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(event_ch.event_res));
        check_field("name_addr", want.name_addr, event_ch.name_addr);
        check_field("data_addr", want.data_addr, event_ch.data_addr);
        check_field("data_len", want.data_len, event_ch.data_len);
        if (event_ch.event_res <= EV_ERROR) ev_seen[event_ch.event_res]++;
      end
    end
  end

  // Watchdog: the run is hung when no request moves on any channel for too long.
  always @(posedge clk) begin
    if ((word_ch.valid && word_ch.ready) || (event_ch.valid && event_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t ns: no request accepted for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                phase_end;
    logic [WORD_W-1:0] w;
    bit                prev_reg;

    errors        = 0;
    words_sent    = 0;
    reg_writes    = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    pressure_done = 1'b0;
    prev_reg      = 1'b0;
    foreach (ev_seen[i]) ev_seen[i] = 0;

    reg_shadow  = '0;
    parse_phase = PH_TOKEN;
    parse_pos   = '0;
    skip_left   = '0;
    pend_len    = '0;

    word_ch.valid    <= 1'b0;
    word_ch.word     <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= CFG_STRUCT_BASE;
    cfg_ch.wdata     <= '0;
    rst              <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table. The size limit comes out of reset at zero, which would end
    // the stream at the first token, so the registers are set first. A structure
    // base just below the top of the address space makes the name and data
    // addresses wrap, and the strings base at all ones wraps the name offset.
    row_reg(CFG_SIZE_LIMIT, 32'hFFFF_FFFF);
    row_reg(CFG_STRUCT_BASE, 32'hFFFF_FFF0);
    row_reg(CFG_STRINGS_BASE, 32'hFFFF_FFFF);
    row_reg(CFG_SPARE, 32'hA5A5_5A5A);
    row_word(TOK_NOP, 1'b1, EV_NOP);
    row_word(TOK_BEGIN_NODE, 1'b1, EV_BEGIN, 32'hFFFF_FFF8);
    row_word(32'h6162_6364);
    row_word(32'h6566_0000);
    // Zero-length property: no data words follow the name offset.
    row_word(TOK_PROP);
    row_word(32'h0000_0000);
    row_word(32'hFFFF_FFFF);
    // Five data bytes take two padded words.
    row_word(TOK_PROP);
    row_word(32'h0000_0005);
    row_word(32'h0000_0010);
    row_word(32'hFFFF_FFFF);
    row_word(32'h0000_0000);
    row_word(TOK_END_NODE, 1'b1, EV_END_NODE);
    // This node name address has wrapped past zero.
    row_word(TOK_BEGIN_NODE, 1'b1, EV_BEGIN, 32'h0000_0028);
    row_word(32'hFFFF_FF00);
    row_word(TOK_END_NODE, 1'b1, EV_END_NODE);
    // The limit lands just past the next token: its length, offset and data words
    // sit at or beyond the limit, which must not count as an error.
    row_reg(CFG_STRUCT_BASE, 32'h0000_0000);
    row_reg(CFG_STRINGS_BASE, 32'h0000_0000);
    row_reg(CFG_SIZE_LIMIT, 32'd68);
    row_word(TOK_PROP);
    row_word(32'h0000_0004);
    row_word(32'h0000_0000);
    row_word(32'h1234_5678);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        if (!prev_reg) settle_block();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
        prev_reg = 1'b1;
      end else begin
        send_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        prev_reg = 1'b0;
      end
    end

    // Random part: phases of well-formed token groups, each under its own register
    // setting. The size limit stays well past the bytes that a phase can use.
    while (words_sent < WORD_TARGET) begin
      settle_block();
      write_reg(CFG_STRUCT_BASE, pick_addr());
      write_reg(CFG_STRINGS_BASE, pick_addr());
      write_reg(CFG_SIZE_LIMIT, ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF :
                $urandom_range(parse_pos + 32'd8192, 32'hFFFF_FFFF));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom);
      phase_end = words_sent + $urandom_range(60, 200);
      if (phase_end > WORD_TARGET) phase_end = WORD_TARGET;
      while (words_sent < phase_end) send_token_group();
    end

    // Close the stream in one of the terminal ways, then keep offering words that
    // must not cause any event.
    close_kind = close_t'($urandom_range(0, 3));
    case (close_kind)
      CLOSE_END_TOKEN: begin
        send_word(TOK_END);
      end
      CLOSE_BAD_TOKEN: begin
        case ($urandom_range(0, 3))
          0:       w = 32'h0000_0000;
          1:       w = 32'hFFFF_FFFF;
          2:       w = $urandom_range(5, 8);
          default: w = $urandom | 32'h0000_0010;
        endcase
        send_word(w);
      end
      CLOSE_SIZE_LIMIT: begin
        // Any token word at or past the limit is an error, even a valid one.
        settle_block();
        write_reg(CFG_SIZE_LIMIT, $urandom_range(0, 1) ? 32'h0000_0000 : parse_pos);
        send_word($urandom_range(0, 1) ? TOK_NOP : $urandom);
      end
      default: begin
        // A length near the top of the range leaves the parser skipping data
        // for far longer than the run lasts.
        case ($urandom_range(0, 2))
          0:       w = 32'hFFFF_FFFF;
          1:       w = 32'hFFFF_FFFD;
          default: w = $urandom | 32'h8000_0000;
        endcase
        send_word(TOK_PROP);
        send_word(w);
        send_word($urandom);
      end
    endcase
    repeat (12) send_word($urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom);

    settle_block();
    $display("covered %0d words and %0d register writes, closed by %s at byte %0d",
             words_sent, reg_writes, close_kind.name(), parse_pos);
    $display("events checked: %0d begin, %0d end node, %0d property, %0d nop, %0d end, %0d error",
             ev_seen[EV_BEGIN], ev_seen[EV_END_NODE], ev_seen[EV_PROP], ev_seen[EV_NOP],
             ev_seen[EV_END], ev_seen[EV_ERROR]);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
